// ----- design/sbht_pkg.sv -----
// Shared widths, types and register codes for the segment against box hit test.
package sbht_pkg;

	// World coordinate width and derived datapath widths.
	localparam int COORD_BITS = 24;
	localparam int DLW = COORD_BITS + 1;      // segment delta and position difference
	localparam int FW = COORD_BITS + 2;       // face offsets and bounds
	localparam int PW = DLW + FW;             // product magnitude
	localparam int QB = COORD_BITS + 1;       // quotient bits below the saturation point
	localparam int QSW = QB + 2;              // signed saturated quotient
	localparam int DIV_LAT = QB + 2;          // divider pipeline depth
	localparam int EXT_W = 16;
	localparam int YAW_W = 16;
	localparam int IDX_W = 3;

	// A heading within an eighth turn of a quarter turn swaps the x and z extents.
	localparam logic [YAW_W-1:0] YAW_BIAS = 16'h2000;
	localparam logic [YAW_W-1:0] YAW_SWAP_MASK = 16'h4000;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_X_LO = 3'd0;
	localparam logic [IDX_W-1:0] REG_X_HI = 3'd1;
	localparam logic [IDX_W-1:0] REG_Y_LO = 3'd2;
	localparam logic [IDX_W-1:0] REG_Y_HI = 3'd3;
	localparam logic [IDX_W-1:0] REG_Z_LO = 3'd4;
	localparam logic [IDX_W-1:0] REG_Z_HI = 3'd5;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [EXT_W-1:0] ext_t;

	// One query as unpacked from the input stream.
	typedef struct packed {
		coord_t src_x;
		coord_t src_y;
		coord_t src_z;
		coord_t dst_x;
		coord_t dst_y;
		coord_t dst_z;
		coord_t box_x;
		coord_t box_y;
		coord_t box_z;
		logic [YAW_W-1:0] box_yaw;
	} query_t;

	// Box extents held in configuration.
	typedef struct packed {
		ext_t x_lo;
		ext_t x_hi;
		ext_t y_lo;
		ext_t y_hi;
		ext_t z_lo;
		ext_t z_hi;
	} extents_t;

	// Decision data that travels alongside the dividers.
	typedef struct packed {
		logic nz;
		logic signed [FW-1:0] ylo;
		logic signed [FW-1:0] yhi;
		logic signed [FW-1:0] mlo;
		logic signed [FW-1:0] mhi;
		logic [1:0] face_ok;
		logic [1:0] neg_y;
		logic [1:0] neg_m;
	} slab_ctl_t;

endpackage

// ----- design/segment_box_hit_test.sv -----
// Top level: stream ports, extent registers, dividers and the final slab decision.
//
//  channel   group      accepted when                payload
//  input     s_axis_*   s_axis_tvalid & tready       one segment and box query
//  output    m_axis_*   m_axis_tvalid & tready       hit flag
//  config    cfg_*      cfg_valid & cfg_ready        register index and value
//
// An item passes DIV_LAT + 5 register stages (32 at 24-bit coordinates); the bit-per-stage
// dividers set this depth.
// A new item is taken every cycle while the output is not stalled.
// Reset clears the valid bits and the extent registers.
// A stalled output freezes the whole pipeline; s_axis_tready is low only then.
module segment_box_hit_test (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// src_x, src_y, src_z, dst_x, dst_y, dst_z, box_x, box_y, box_z, box_yaw
	input  logic [9*sbht_pkg::COORD_BITS+sbht_pkg::YAW_W-1:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// hit, then zero fill
	output logic [7:0]   m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [sbht_pkg::IDX_W-1:0] cfg_index,
	input  logic [sbht_pkg::EXT_W-1:0] cfg_data
);
	import sbht_pkg::*;

	localparam int C = COORD_BITS;

	extents_t ext_q;
	query_t query;
	logic adv, fv, out_v_q, hit_q;
	slab_ctl_t fctl;
	logic [DLW-1:0] amaj;
	logic [PW-1:0] py0, py1, pm0, pm1;
	logic signed [QSW-1:0] qy0, qy1, qm0, qm1;
	slab_ctl_t ctl_d [0:DIV_LAT-1];
	logic v_d [0:DIV_LAT-1];
	slab_ctl_t cd;
	logic signed [QSW-1:0] ylo, yhi, mlo, mhi;
	logic in0, in1, h0, h1, b0, b1, a0, a1, hit;

	assign adv = !out_v_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign cfg_ready = 1'b1;

	// Unpack the input transfer, first field lowest.
	assign query.src_x   = s_axis_tdata[0*C +: C];
	assign query.src_y   = s_axis_tdata[1*C +: C];
	assign query.src_z   = s_axis_tdata[2*C +: C];
	assign query.dst_x   = s_axis_tdata[3*C +: C];
	assign query.dst_y   = s_axis_tdata[4*C +: C];
	assign query.dst_z   = s_axis_tdata[5*C +: C];
	assign query.box_x   = s_axis_tdata[6*C +: C];
	assign query.box_y   = s_axis_tdata[7*C +: C];
	assign query.box_z   = s_axis_tdata[8*C +: C];
	assign query.box_yaw = s_axis_tdata[9*C +: YAW_W];

	// Extent registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_X_LO: ext_q.x_lo <= cfg_data;
				REG_X_HI: ext_q.x_hi <= cfg_data;
				REG_Y_LO: ext_q.y_lo <= cfg_data;
				REG_Y_HI: ext_q.y_hi <= cfg_data;
				REG_Z_LO: ext_q.z_lo <= cfg_data;
				REG_Z_HI: ext_q.z_hi <= cfg_data;
				default: ;
			endcase
		end
	end

	sbht_front u_front (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(s_axis_tvalid), .query(query), .ext(ext_q),
		.out_valid(fv), .ctl(fctl), .amaj(amaj),
		.prod_y0(py0), .prod_y1(py1), .prod_m0(pm0), .prod_m1(pm1)
	);

	sbht_div u_div_y0 (.clk(clk), .adv(adv), .dividend(py0), .divisor(amaj),
		.neg(fctl.neg_y[0]), .quot(qy0));
	sbht_div u_div_y1 (.clk(clk), .adv(adv), .dividend(py1), .divisor(amaj),
		.neg(fctl.neg_y[1]), .quot(qy1));
	sbht_div u_div_m0 (.clk(clk), .adv(adv), .dividend(pm0), .divisor(amaj),
		.neg(fctl.neg_m[0]), .quot(qm0));
	sbht_div u_div_m1 (.clk(clk), .adv(adv), .dividend(pm1), .divisor(amaj),
		.neg(fctl.neg_m[1]), .quot(qm1));

	// Control and valid bits ride alongside the dividers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) begin
				v_d[i] <= 1'b0;
			end
		end else if (adv) begin
			v_d[0] <= fv;
			for (int i = 1; i < DIV_LAT; i++) begin
				v_d[i] <= v_d[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_d[0] <= fctl;
			for (int i = 1; i < DIV_LAT; i++) begin
				ctl_d[i] <= ctl_d[i-1];
			end
		end
	end

	// Slab decision: a face hit, or the two faces straddling the minor range.
	always_comb begin
		cd  = ctl_d[DIV_LAT-1];
		ylo = QSW'(cd.ylo);
		yhi = QSW'(cd.yhi);
		mlo = QSW'(cd.mlo);
		mhi = QSW'(cd.mhi);
		in0 = cd.face_ok[0] && (qy0 > ylo) && (qy0 < yhi);
		in1 = cd.face_ok[1] && (qy1 > ylo) && (qy1 < yhi);
		b0  = in0 && (qm0 < mlo);
		b1  = in1 && (qm1 < mlo);
		a0  = in0 && (qm0 > mhi);
		a1  = in1 && (qm1 > mhi);
		h0  = in0 && !b0 && !a0;
		h1  = in1 && !b1 && !a1;
		hit = cd.nz && (h0 || h1 || (b0 && a1) || (a0 && b1));
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_d[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q <= hit;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {7'b0, hit_q};

endmodule

// ----- design/sbht_front.sv -----
// Front pipeline: deltas, extent swap, major axis choice, magnitudes and products.
module sbht_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   in_valid,
	input  sbht_pkg::query_t       query,
	input  sbht_pkg::extents_t     ext,
	output logic                   out_valid,
	output sbht_pkg::slab_ctl_t    ctl,
	output logic [sbht_pkg::DLW-1:0] amaj,
	output logic [sbht_pkg::PW-1:0]  prod_y0,
	output logic [sbht_pkg::PW-1:0]  prod_y1,
	output logic [sbht_pkg::PW-1:0]  prod_m0,
	output logic [sbht_pkg::PW-1:0]  prod_m1
);
	import sbht_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;

	// Stage 1 registers.
	logic signed [DLW-1:0] dx_s1, dy_s1, dz_s1, rx_s1, ry_s1, rz_s1;
	logic swap_s1;
	logic [YAW_W-1:0] yaw_biased;

	// Stage 2 registers.
	logic signed [DLW-1:0] dx_s2, dy_s2, dz_s2;
	logic [DLW-1:0] adx_s2, adz_s2;
	logic signed [FW-1:0] ylo_s2, yhi_s2, xlo_s2, xhi_s2, zlo_s2, zhi_s2;
	ext_t xl, xh, zl, zh;

	// Stage 3 registers.
	slab_ctl_t ctl_s3;
	logic [DLW-1:0] amaj_s3, ady_s3, adm_s3;
	logic [FW-1:0] af0_s3, af1_s3;
	logic zmaj;
	logic signed [DLW-1:0] major, dm;
	logic signed [FW-1:0] f0, f1;

	// Stage 4 registers.
	slab_ctl_t ctl_s4;
	logic [DLW-1:0] amaj_s4;
	logic [PW-1:0] py0_s4, py1_s4, pm0_s4, pm1_s4;

	// Valid bits move with the data whenever the pipeline advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign yaw_biased = query.box_yaw + YAW_BIAS;

	// Stage 1: segment deltas and box position relative to the source.
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= DLW'(query.dst_x) - DLW'(query.src_x);
			dy_s1 <= DLW'(query.dst_y) - DLW'(query.src_y);
			dz_s1 <= DLW'(query.dst_z) - DLW'(query.src_z);
			rx_s1 <= DLW'(query.box_x) - DLW'(query.src_x);
			ry_s1 <= DLW'(query.box_y) - DLW'(query.src_y);
			rz_s1 <= DLW'(query.box_z) - DLW'(query.src_z);
			swap_s1 <= (yaw_biased & YAW_SWAP_MASK) != '0;
		end
	end

	// Near a quarter turn the x and z extent pairs trade places.
	always_comb begin
		xl = swap_s1 ? ext.z_lo : ext.x_lo;
		xh = swap_s1 ? ext.z_hi : ext.x_hi;
		zl = swap_s1 ? ext.x_lo : ext.z_lo;
		zh = swap_s1 ? ext.x_hi : ext.z_hi;
	end

	// Stage 2: bounds relative to the source and horizontal magnitudes.
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			dz_s2  <= dz_s1;
			adx_s2 <= dx_s1[DLW-1] ? DLW'(-dx_s1) : DLW'(dx_s1);
			adz_s2 <= dz_s1[DLW-1] ? DLW'(-dz_s1) : DLW'(dz_s1);
			ylo_s2 <= FW'(ry_s1) + FW'(ext.y_lo);
			yhi_s2 <= FW'(ry_s1) + FW'(ext.y_hi);
			xlo_s2 <= FW'(rx_s1) + FW'(xl);
			xhi_s2 <= FW'(rx_s1) + FW'(xh);
			zlo_s2 <= FW'(rz_s1) + FW'(zl);
			zhi_s2 <= FW'(rz_s1) + FW'(zh);
		end
	end

	// Major axis is z only when its magnitude is strictly larger.
	always_comb begin
		zmaj  = adz_s2 > adx_s2;
		major = zmaj ? dz_s2 : dx_s2;
		dm    = zmaj ? dx_s2 : dz_s2;
		f0    = zmaj ? zlo_s2 : xlo_s2;
		f1    = zmaj ? zhi_s2 : xhi_s2;
	end

	// Stage 3: face selection, sign bookkeeping and operand magnitudes.
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s3.nz         <= major != '0;
			ctl_s3.ylo        <= ylo_s2;
			ctl_s3.yhi        <= yhi_s2;
			ctl_s3.mlo        <= zmaj ? xlo_s2 : zlo_s2;
			ctl_s3.mhi        <= zmaj ? xhi_s2 : zhi_s2;
			ctl_s3.face_ok[0] <= major[DLW-1] == f0[FW-1];
			ctl_s3.face_ok[1] <= major[DLW-1] == f1[FW-1];
			ctl_s3.neg_y[0]   <= dy_s2[DLW-1] ^ f0[FW-1] ^ major[DLW-1];
			ctl_s3.neg_y[1]   <= dy_s2[DLW-1] ^ f1[FW-1] ^ major[DLW-1];
			ctl_s3.neg_m[0]   <= dm[DLW-1] ^ f0[FW-1] ^ major[DLW-1];
			ctl_s3.neg_m[1]   <= dm[DLW-1] ^ f1[FW-1] ^ major[DLW-1];
			amaj_s3 <= major[DLW-1] ? DLW'(-major) : DLW'(major);
			ady_s3  <= dy_s2[DLW-1] ? DLW'(-dy_s2) : DLW'(dy_s2);
			adm_s3  <= dm[DLW-1] ? DLW'(-dm) : DLW'(dm);
			af0_s3  <= f0[FW-1] ? FW'(-f0) : FW'(f0);
			af1_s3  <= f1[FW-1] ? FW'(-f1) : FW'(f1);
		end
	end

	// Stage 4: the four delta by face offset products.
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s4  <= ctl_s3;
			amaj_s4 <= amaj_s3;
			py0_s4  <= PW'(ady_s3) * PW'(af0_s3);
			py1_s4  <= PW'(ady_s3) * PW'(af1_s3);
			pm0_s4  <= PW'(adm_s3) * PW'(af0_s3);
			pm1_s4  <= PW'(adm_s3) * PW'(af1_s3);
		end
	end

	assign out_valid = v_s4;
	assign ctl       = ctl_s4;
	assign amaj      = amaj_s4;
	assign prod_y0   = py0_s4;
	assign prod_y1   = py1_s4;
	assign prod_m0   = pm0_s4;
	assign prod_m1   = pm1_s4;

endmodule

// ----- design/sbht_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, saturated signed result.
module sbht_div (
	input  logic                          clk,
	input  logic                          adv,
	input  logic [sbht_pkg::PW-1:0]       dividend,
	input  logic [sbht_pkg::DLW-1:0]      divisor,
	input  logic                          neg,
	output logic signed [sbht_pkg::QSW-1:0] quot
);
	import sbht_pkg::*;

	localparam logic [QB:0] SAT_MAG = (QB+1)'(1) << QB;

	logic [DLW-1:0] rem_s [0:QB];
	logic [QB-1:0]  lo_s  [0:QB];
	logic [QB-1:0]  q_s   [0:QB];
	logic [DLW-1:0] ud_s  [0:QB];
	logic           sat_s [0:QB];
	logic           neg_s [0:QB];
	logic [QB:0]    qmag;

	// First stage: saturate when the quotient reaches the limit, else seed the remainder.
	always_ff @(posedge clk) begin
		if (adv) begin
			sat_s[0] <= dividend >= (PW'(divisor) << QB);
			rem_s[0] <= DLW'(dividend >> QB);
			lo_s[0]  <= dividend[QB-1:0];
			q_s[0]   <= '0;
			ud_s[0]  <= divisor;
			neg_s[0] <= neg;
		end
	end

	// One trial subtraction per stage.
	for (genvar k = 1; k <= QB; k++) begin : g_step
		logic [DLW:0] rs;
		logic ge;
		assign rs = {rem_s[k-1], lo_s[k-1][QB-1]};
		assign ge = rs >= {1'b0, ud_s[k-1]};
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k] <= ge ? DLW'(rs - {1'b0, ud_s[k-1]}) : DLW'(rs);
				lo_s[k]  <= lo_s[k-1] << 1;
				q_s[k]   <= {q_s[k-1][QB-2:0], ge};
				ud_s[k]  <= ud_s[k-1];
				sat_s[k] <= sat_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	assign qmag = sat_s[QB] ? SAT_MAG : {1'b0, q_s[QB]};

	// Output stage applies the sign.
	always_ff @(posedge clk) begin
		if (adv) begin
			quot <= neg_s[QB] ? -$signed(QSW'(qmag)) : $signed(QSW'(qmag));
		end
	end

endmodule
